// ===== rtl/lfyp_pkg.sv =====
// Shared types and constants for the seeded Fisher-Yates pick block.
`default_nettype none

package lfyp_pkg;

   // Default sizes, handed to the top level parameters
   localparam int MAX_ELEMENTS_DEF = 16;
   localparam int PICK_COUNT_DEF   = 3;

   // Field widths fixed by the interface
   localparam int CFG_W  = 5;
   localparam int SEED_W = 32;
   localparam int PICK_W = 4;

   // Linear congruential generator
   localparam logic [SEED_W-1:0] LCG_MUL   = 32'd1103515245;
   localparam logic [SEED_W-1:0] LCG_ADD   = 32'd12345;
   localparam int                LCG_SHIFT = 16;

   // Dividend of the partner modulo: generator bits 31..16
   localparam int DIV_W    = SEED_W - LCG_SHIFT;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // Reset value of element_count
   localparam logic [CFG_W-1:0] COUNT_RESET = 5'd16;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_RD_TOP,
      ST_RD_J,
      ST_WR_TOP,
      ST_WR_J,
      ST_PICK_RD,
      ST_PICK_OUT
   } state_type;

   // Store read address source
   typedef enum logic [1:0] {
      RD_SEL_TOP,
      RD_SEL_J,
      RD_SEL_POS
   } rd_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load;     // take seed and count, start a transaction
      logic       fill;     // write identity entry at pos, advance pos
      logic       mul;      // register generator times multiplier
      logic       add;      // finish generator step, arm divider
      logic       div;      // one restoring division step
      rd_sel_type rd_sel;
      logic       cap_a;    // hold entry read from top position
      logic       wr_top;   // write entry j into top position
      logic       wr_j;     // write held top entry into position j
      logic       top_dec;  // move to next lower top position
      logic       pos_clr;
      logic       pos_inc;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic fill_last;    // pos at last store entry
      logic run_shuffle;  // count above one
      logic div_last;     // final division step
      logic top_is_one;   // last shuffle pass
      logic pick_last;    // pos at final pick
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/lfyp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lfyp_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/lfyp_datapath.sv =====
// Datapath: generator, partner divider, permutation store and counters.
`default_nettype none

module lfyp_datapath #(
   parameter int MAX_ELEMENTS = lfyp_pkg::MAX_ELEMENTS_DEF,
   parameter int PICK_COUNT   = lfyp_pkg::PICK_COUNT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lfyp_pkg::cmd_type             cmd,
   output lfyp_pkg::sts_type                  sts,
   input  wire logic [lfyp_pkg::SEED_W-1:0]   req_seed,
   input  wire logic                          csr_wr,
   input  wire logic [lfyp_pkg::CFG_W-1:0]    csr_element_count,
   output logic      [lfyp_pkg::PICK_W-1:0]   pick_index
);

   import lfyp_pkg::*;

   localparam int DEPTH = (MAX_ELEMENTS > PICK_COUNT) ? MAX_ELEMENTS : PICK_COUNT;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int EXT_W = (IDX_W > PICK_W) ? IDX_W : PICK_W;

   logic [CFG_W-1:0]   count_ff;
   logic [SEED_W-1:0]  gen_ff, gen_in;
   logic [SEED_W-1:0]  prod_ff;
   logic [DIV_W-1:0]   dvd_ff;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] step_ff;
   logic [IDX_W-1:0]   top_ff;
   logic [IDX_W-1:0]   pos_ff;
   logic               shuffle_ff;
   logic [IDX_W-1:0]   a_ff;

   logic [CMP_W-1:0]   count_ext;
   logic [CNT_W-1:0]   count_sat;
   logic [CNT_W-1:0]   divisor;
   logic [CNT_W:0]     trial;
   logic [IDX_W-1:0]   j_idx;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   rd_data;
   logic [EXT_W-1:0]   rd_ext;

   // Saturate the configured count to the store size
   assign count_ext = CMP_W'(count_ff);
   assign count_sat = (count_ext > CMP_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                         : CNT_W'(count_ext);

   // Divisor of the current pass is top + 1
   assign divisor = CNT_W'(top_ff) + CNT_W'(1);
   assign trial   = {rem_ff, dvd_ff[DIV_W-1]};
   assign rem_in  = (trial >= (CNT_W+1)'(divisor)) ? CNT_W'(trial - (CNT_W+1)'(divisor))
                                                   : CNT_W'(trial);
   assign j_idx   = rem_ff[IDX_W-1:0];

   assign gen_in  = prod_ff + LCG_ADD;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_wr) begin
         count_ff <= csr_element_count;
      end
   end

   // Generator value
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= '0;
      end else if (cmd.load) begin
         gen_ff <= req_seed;
      end else if (cmd.add) begin
         gen_ff <= gen_in;
      end
   end

   // Product register, then divider: one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= gen_ff * LCG_MUL;
      end
      if (cmd.add) begin
         dvd_ff  <= gen_in[SEED_W-1:LCG_SHIFT];
         rem_ff  <= '0;
      end else if (cmd.div) begin
         dvd_ff  <= {dvd_ff[DIV_W-2:0], 1'b0};
         rem_ff  <= rem_in;
      end
   end

   // Division step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.add) begin
         step_ff <= '0;
      end else if (cmd.div) begin
         step_ff <= step_ff + DIV_CNT_W'(1);
      end
   end

   // Top position and shuffle flag
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff     <= '0;
         shuffle_ff <= 1'b0;
      end else if (cmd.load) begin
         top_ff     <= IDX_W'(count_sat - CNT_W'(1));
         shuffle_ff <= (count_sat > CNT_W'(1));
      end else if (cmd.top_dec) begin
         top_ff     <= top_ff - IDX_W'(1);
      end
   end

   // Fill and pick position
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (cmd.load || cmd.pos_clr) begin
         pos_ff <= '0;
      end else if (cmd.fill || cmd.pos_inc) begin
         pos_ff <= pos_ff + IDX_W'(1);
      end
   end

   // Hold the entry read from the top position
   always_ff @(posedge clock) begin
      if (cmd.cap_a) begin
         a_ff <= rd_data;
      end
   end

   // Store port selection
   always_comb begin
      wr_en   = cmd.fill || cmd.wr_top || cmd.wr_j;
      wr_addr = pos_ff;
      wr_data = pos_ff;
      if (cmd.wr_top) begin
         wr_addr = top_ff;
         wr_data = rd_data;
      end else if (cmd.wr_j) begin
         wr_addr = j_idx;
         wr_data = a_ff;
      end
      unique case (cmd.rd_sel)
         RD_SEL_TOP: rd_addr = top_ff;
         RD_SEL_J:   rd_addr = j_idx;
         RD_SEL_POS: rd_addr = pos_ff;
         default:    rd_addr = pos_ff;
      endcase
   end

   lfyp_ram #(
      .WIDTH (IDX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Mask the entry to the result width
   assign rd_ext     = EXT_W'(rd_data);
   assign pick_index = rd_ext[PICK_W-1:0];

   // Status to the controller
   assign sts.fill_last   = (pos_ff == IDX_W'(DEPTH - 1));
   assign sts.run_shuffle = shuffle_ff;
   assign sts.div_last    = (step_ff == DIV_CNT_W'(DIV_W - 1));
   assign sts.top_is_one  = (top_ff == IDX_W'(1));
   assign sts.pick_last   = (pos_ff == IDX_W'(PICK_COUNT - 1));

   // Partner index lies below the divisor once division is done
   a_partner_range: assert property (@(posedge clock) disable iff (reset)
      cmd.cap_a |-> (rem_ff < divisor))
      else $error("swap partner not below divisor");

   // Swaps only happen on a nonzero top position
   a_top_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_j |-> (top_ff != '0))
      else $error("swap at top position zero");

endmodule

`default_nettype wire

// ===== rtl/lfyp_ctrl.sv =====
// Controller state machine sequencing fill, shuffle passes and picks.
`default_nettype none

module lfyp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire lfyp_pkg::sts_type sts,
   output lfyp_pkg::cmd_type      cmd,
   output logic                   rsp_strobe,
   output logic                   rsp_last_pick
);

   import lfyp_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_SEL_POS;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (sts.fill_last) begin
               cmd.pos_clr = 1'b1;
               state_in    = sts.run_shuffle ? ST_MUL : ST_PICK_RD;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (sts.div_last) begin
               state_in = ST_RD_TOP;
            end
         end
         ST_RD_TOP: begin
            cmd.rd_sel = RD_SEL_TOP;
            state_in   = ST_RD_J;
         end
         ST_RD_J: begin
            cmd.rd_sel = RD_SEL_J;
            cmd.cap_a  = 1'b1;
            state_in   = ST_WR_TOP;
         end
         ST_WR_TOP: begin
            cmd.wr_top = 1'b1;
            state_in   = ST_WR_J;
         end
         ST_WR_J: begin
            cmd.wr_j = 1'b1;
            if (sts.top_is_one) begin
               state_in = ST_PICK_RD;
            end else begin
               cmd.top_dec = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_PICK_RD: begin
            state_in = ST_PICK_OUT;
         end
         ST_PICK_OUT: begin
            if (sts.pick_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.pos_inc = 1'b1;
               state_in    = ST_PICK_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = (state_ff == ST_PICK_OUT);
   assign rsp_last_pick = rsp_strobe && sts.pick_last;

   // An accepted transaction makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("start accepted but block not busy");

   // Results are spaced by a store read state
   a_pick_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_pick) |=> !rsp_strobe)
      else $error("back-to-back result strobes");

   // Block goes idle after the final result
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_last_pick |=> !busy)
      else $error("still busy after final result");

endmodule

`default_nettype wire

// ===== rtl/lcg_fisher_yates_pick_core.sv =====
// Top level: seeded Fisher-Yates shuffle returning the front picks.
//
// A seed is taken when start is high and busy is low. The block fills its
// permutation store with the identity (one entry a cycle), then runs one
// shuffle pass per top index from count-1 down to 1. Each pass runs the
// generator multiply and add, a 16-step bit-serial modulo for the swap
// partner, and two reads and two writes on the store, which has one write
// port and one read port. The picks then come out on rsp_strobe, each after
// a store read state, the last one marked by rsp_last_pick; the receiver
// cannot stall them. There are no shuffle passes at all for a count below
// two. The fill covers DEPTH entries, where DEPTH is the larger of
// MAX_ELEMENTS and PICK_COUNT. element_count may be written through the csr
// port while busy and start are both low; values above MAX_ELEMENTS act as
// MAX_ELEMENTS.
`default_nettype none

module lcg_fisher_yates_pick_core #(
   parameter int MAX_ELEMENTS = lfyp_pkg::MAX_ELEMENTS_DEF,
   parameter int PICK_COUNT   = lfyp_pkg::PICK_COUNT_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [lfyp_pkg::SEED_W-1:0] req_seed,
   output logic                             rsp_strobe,
   output logic      [lfyp_pkg::PICK_W-1:0] rsp_pick_index,
   output logic                             rsp_last_pick,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [lfyp_pkg::CFG_W-1:0]  csr_element_count
);

   import lfyp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Accept register writes only while idle and no seed is offered
   assign csr_ready = !busy && !start;

   lfyp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .sts           (sts),
      .cmd           (cmd),
      .rsp_strobe    (rsp_strobe),
      .rsp_last_pick (rsp_last_pick)
   );

   lfyp_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .PICK_COUNT   (PICK_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_seed          (req_seed),
      .csr_wr            (csr_valid && csr_ready),
      .csr_element_count (csr_element_count),
      .pick_index        (rsp_pick_index)
   );

endmodule

`default_nettype wire

// ===== tb/lcg_fisher_yates_pick_core_checker.sv =====
// Checker for the Fisher-Yates pick block: predicts the picks of each seed and compares them.
`timescale 1ns / 1ps

module lcg_fisher_yates_pick_core_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic                             busy,
   input  wire logic [lfyp_pkg::SEED_W-1:0]      req_seed,
   input  wire logic                             rsp_strobe,
   input  wire logic [lfyp_pkg::PICK_W-1:0]      rsp_pick_index,
   input  wire logic                             rsp_last_pick,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_ready,
   input  wire logic [lfyp_pkg::CFG_W-1:0]       csr_element_count,
   output int                                    fail_count,
   output int                                    picks_due,
   output int                                    seeds_taken,
   output int                                    picks_taken,
   output int                                    counts_written
);

   import lfyp_pkg::*;

   localparam int ELEMENTS    = MAX_ELEMENTS_DEF;
   localparam int PICKS       = PICK_COUNT_DEF;
   localparam int ORDER_DEPTH = (ELEMENTS > PICKS) ? ELEMENTS : PICKS;

   typedef struct packed {
      logic [PICK_W-1:0] pick_index;
      logic              last_pick;
   } pick_type;

   pick_type          picks_expected[$];
   logic [CFG_W-1:0]  shuffle_count;

   initial begin
      fail_count     = 0;
      picks_due      = 0;
      seeds_taken    = 0;
      picks_taken    = 0;
      counts_written = 0;
      shuffle_count  = COUNT_RESET;
   end

   // Count a failure, report only the first few
   task automatic flag_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // Shuffle the identity with the seeded generator, queue the front picks
   task automatic queue_shuffle_picks(input logic [SEED_W-1:0] seed);
      logic [PICK_W-1:0] order [ORDER_DEPTH];
      logic [SEED_W-1:0] lcg;
      logic [PICK_W-1:0] held;
      pick_type          pick;
      int                span;
      int                top;
      int                partner;
      span = (int'(shuffle_count) > ELEMENTS) ? ELEMENTS : int'(shuffle_count);
      lcg  = seed;
      for (int k = 0; k < ORDER_DEPTH; k++)
         order[k] = PICK_W'(k);
      for (top = span - 1; top >= 1; top--) begin
         lcg            = lcg * LCG_MUL + LCG_ADD;
         partner        = int'({16'd0, lcg[SEED_W-1:LCG_SHIFT]} % 32'(top + 1));
         held           = order[top];
         order[top]     = order[partner];
         order[partner] = held;
      end
      for (int k = 0; k < PICKS; k++) begin
         pick.pick_index = order[k];
         pick.last_pick  = (k == PICKS - 1);
         picks_expected.push_back(pick);
      end
   endtask

   // Watch all three channels at each edge
   always @(posedge clock) begin
      pick_type want;
      if (reset) begin
         shuffle_count = COUNT_RESET;
      end else begin
         if (rsp_strobe) begin
            picks_taken++;
            if (picks_expected.size() == 0) begin
               flag_mismatch($sformatf("unexpected pick %0d last %0b",
                                       rsp_pick_index, rsp_last_pick));
            end else begin
               want = picks_expected.pop_front();
               if (rsp_pick_index !== want.pick_index)
                  flag_mismatch($sformatf("pick_index expected %0d got %0d",
                                          want.pick_index, rsp_pick_index));
               if (rsp_last_pick !== want.last_pick)
                  flag_mismatch($sformatf("last_pick expected %0b got %0b",
                                          want.last_pick, rsp_last_pick));
            end
         end
         if (start && !busy) begin
            seeds_taken++;
            queue_shuffle_picks(req_seed);
         end
         if (csr_valid && csr_ready) begin
            counts_written++;
            shuffle_count = csr_element_count;
         end
      end
      picks_due = picks_expected.size();
   end

endmodule

// ===== tb/lcg_fisher_yates_pick_core_tb.sv =====
// Testbench top: clock, reset, seed and element_count stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module lcg_fisher_yates_pick_core_tb;

   import lfyp_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 400;
   localparam int PHASES      = 8;
   localparam int PHASE_SEEDS = 13;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic [SEED_W-1:0] req_seed;
   logic              rsp_strobe;
   logic [PICK_W-1:0] rsp_pick_index;
   logic              rsp_last_pick;
   logic              csr_valid;
   logic              csr_ready;
   logic [CFG_W-1:0]  csr_element_count;

   int fail_count;
   int picks_due;
   int seeds_taken;
   int picks_taken;
   int counts_written;
   int stall_cycles = 0;
   bit quiet        = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   lcg_fisher_yates_pick_core u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_seed          (req_seed),
      .rsp_strobe        (rsp_strobe),
      .rsp_pick_index    (rsp_pick_index),
      .rsp_last_pick     (rsp_last_pick),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_element_count (csr_element_count)
   );

   lcg_fisher_yates_pick_core_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_seed          (req_seed),
      .rsp_strobe        (rsp_strobe),
      .rsp_pick_index    (rsp_pick_index),
      .rsp_last_pick     (rsp_last_pick),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_element_count (csr_element_count),
      .fail_count        (fail_count),
      .picks_due         (picks_due),
      .seeds_taken       (seeds_taken),
      .picks_taken       (picks_taken),
      .counts_written    (counts_written)
   );

   // Drop the run if nothing moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("lcg_fisher_yates_pick_core test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Random hold-off; long enough to land anywhere in a shuffle
   function automatic int idle_gap();
      if (!quiet && $urandom_range(99) < 15)
         return $urandom_range(1, 360);
      return 0;
   endfunction

   // Offer one seed and hold it until the block takes it
   task automatic send_seed(input logic [SEED_W-1:0] seed);
      int  gap;
      bit  taken;
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_seed <= seed;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   // Drain all picks, then write element_count
   task automatic write_count(input logic [CFG_W-1:0] value);
      int  gap;
      bit  taken;
      start <= 1'b0;
      do @(negedge clock); while (picks_due != 0 || busy);
      @(posedge clock);
      gap = idle_gap();
      repeat (gap) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_element_count <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [CFG_W-1:0] count;
      reset             = 1'b1;
      start             = 1'b0;
      req_seed          = '0;
      csr_valid         = 1'b0;
      csr_element_count = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset count, seed extremes
      send_seed(32'h0000_0000);
      send_seed(32'hFFFF_FFFF);
      send_seed(32'h8000_0000);
      send_seed(32'h7FFF_FFFF);
      send_seed(32'h1234_5678);
      // Counts of zero and one: no passes at all
      write_count(5'd0);
      send_seed(32'h0000_0000);
      send_seed(32'hFFFF_FFFF);
      write_count(5'd1);
      send_seed(32'h0000_0001);
      // Count of two: third pick keeps its identity
      write_count(5'd2);
      send_seed(32'h0000_0000);
      send_seed(32'h5555_5555);
      write_count(5'd3);
      send_seed(32'hAAAA_AAAA);
      send_seed(32'h0000_0001);
      // Counts above the store size saturate
      write_count(5'd17);
      send_seed(32'hDEAD_BEEF);
      write_count(5'd31);
      send_seed(32'h0000_0000);
      send_seed(32'hFFFF_FFFF);
      write_count(5'd16);
      send_seed(32'hC0FF_EE00);

      // Random phases, mostly in the meaningful count range
      for (int p = 0; p < PHASES; p++) begin
         quiet = (p == 3 || p == 4);
         if ($urandom_range(9) < 7)
            count = CFG_W'($urandom_range(3, 16));
         else
            count = CFG_W'($urandom_range(0, 31));
         write_count(count);
         for (int s = 0; s < PHASE_SEEDS; s++)
            send_seed($urandom);
      end
      quiet = 1'b0;
      start <= 1'b0;

      // Let every pick arrive, then watch for strays
      do @(negedge clock); while (picks_due != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d seeds and %0d picks over %0d element_count writes,",
               seeds_taken, picks_taken, counts_written);
      $display("including counts 0, 1, 2, 3, 16, 17 and 31; %0d failures.", fail_count);
      if (fail_count == 0 && picks_due == 0)
         $display("lcg_fisher_yates_pick_core test passed");
      else
         $display("lcg_fisher_yates_pick_core test failed");
      $finish;
   end

endmodule
